// ===== rtl/i2cw_pkg.sv =====
`default_nettype none

package i2cw_pkg;

    // configuration register indexes and widths
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_UNITS = 1'b1;

    // register reset values
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd1000;
    localparam logic [7:0]  HOLD_UNITS_RESET = 8'd2;

    // default depth of the command and result queues
    localparam int QUEUE_DEPTH = 2;

    // index of the last data bit of a byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // input item
    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_item;

    // result item
    typedef struct packed {
        logic scl_out;
        logic sda_out;
        logic busy_res;
        logic done_res;
        logic nack;
    } t_out_item;

    // command kinds
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SEND = 1'b1
    } t_cmd_kind;

    // classified command between front and back
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_cmd;

    // timing configuration
    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [7:0]  hold_units;
    } t_cfg;

    // bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_HIGH = 4'd1,
        PH_START_LOW  = 4'd2,
        PH_BIT_LOW    = 4'd3,
        PH_BIT_SET    = 4'd4,
        PH_BIT_HIGH   = 4'd5,
        PH_ACK_REL    = 4'd6,
        PH_ACK_HIGH   = 4'd7,
        PH_ACK_LOW    = 4'd8,
        PH_STOP_HIGH  = 4'd9,
        PH_STOP_REL   = 4'd10
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_single_byte_write.sv =====
`default_nettype none

// Tick-driven I2C master that writes one byte per transaction: start, eight data
// bits MSB first, acknowledge sample, stop, with SCL left low at the end. Every
// item pushed (a tick or a send request) yields exactly one result with the bus
// levels after that item, busy, and done with the sampled nack on the item that
// finishes the stop. A send request during a transaction is ignored. Waits are
// counted in units of unit_ticks ticks; a hold lasts hold_units units. Items are
// taken one per clock unless a queue is full: a short command queue feeds a
// sequencer that does one step per cycle into a result queue, so throughput is
// one item per cycle without stalls, each item passing through both queues.
// Configuration writes take effect at once and should be made while idle.
module i2c_master_single_byte_write #(
    parameter int DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 push,
    output logic                                full,
    input  i2cw_pkg::t_in_item                  i_item,
    output logic                                empty,
    input  wire                                 pop,
    output i2cw_pkg::t_out_item                 o_result,
    input  wire                                 i_cfg_we,
    input  wire [i2cw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [i2cw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    i2cw_pkg::t_cfg r_cfg;
    i2cw_pkg::t_cmd w_cmd;
    logic           w_cmd_valid, w_cmd_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_ticks <= i2cw_pkg::UNIT_TICKS_RESET;
            r_cfg.hold_units <= i2cw_pkg::HOLD_UNITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cw_pkg::CFG_UNIT_TICKS: r_cfg.unit_ticks <= i_cfg_data;
                i2cw_pkg::CFG_HOLD_UNITS: r_cfg.hold_units <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // command intake
    i2cw_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // bus sequencer and result queue
    i2cw_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/i2cw_front.sv =====
`default_nettype none

module i2cw_front #(
    parameter int DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                push,
    output logic               full,
    input  i2cw_pkg::t_in_item i_item,
    output logic               o_cmd_valid,
    output i2cw_pkg::t_cmd     o_cmd,
    input  wire                i_cmd_take
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cw_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    i2cw_pkg::t_cmd w_cmd;
    logic           w_enq, w_deq;

    // classify the incoming item
    always_comb begin
        w_cmd.kind      = i_item.opcode ? i2cw_pkg::CMD_SEND : i2cw_pkg::CMD_TICK;
        w_cmd.data_byte = i_item.data_byte;
        w_cmd.sda_in    = i_item.sda_in;
    end

    assign full        = (r_count == CW'(DEPTH));
    assign w_enq       = push && !full;
    assign o_cmd_valid = (r_count != '0);
    assign w_deq       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_enq && !w_deq) begin
                r_count <= r_count + 1'b1;
            end else if (w_deq && !w_enq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2cw_back.sv =====
`default_nettype none

module i2cw_back #(
    parameter int DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  i2cw_pkg::t_cfg      i_cfg,
    input  wire                 i_cmd_valid,
    input  i2cw_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                empty,
    input  wire                 pop,
    output i2cw_pkg::t_out_item o_result
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer state
    i2cw_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic [15:0]      r_tick, n_tick;
    logic [7:0]       r_unit, n_unit;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic             r_ack, n_ack;

    // result queue
    i2cw_pkg::t_out_item r_mem [DEPTH];
    logic [PW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]       r_count;

    logic                w_step, w_deq, w_q_full;
    logic                w_tick, w_send, w_unit_end, w_adv, w_long;
    logic [16:0]         w_tick_inc;
    logic [8:0]          w_unit_inc;
    logic                w_done;
    i2cw_pkg::t_out_item w_res;

    assign w_q_full   = (r_count == CW'(DEPTH));
    assign w_step     = i_cmd_valid && !w_q_full;
    assign o_cmd_take = w_step;
    assign w_deq      = pop && !empty;
    assign empty      = (r_count == '0);
    assign o_result   = r_mem[r_rd_ptr];

    // tick and unit timing
    assign w_tick     = w_step && (i_cmd.kind == i2cw_pkg::CMD_TICK)
                        && (r_phase != i2cw_pkg::PH_IDLE);
    assign w_send     = w_step && (i_cmd.kind == i2cw_pkg::CMD_SEND)
                        && (r_phase == i2cw_pkg::PH_IDLE);
    assign w_tick_inc = {1'b0, r_tick} + 17'd1;
    assign w_unit_inc = {1'b0, r_unit} + 9'd1;
    assign w_unit_end = w_tick && (w_tick_inc >= {1'b0, i_cfg.unit_ticks});
    assign w_long     = (r_phase inside {i2cw_pkg::PH_START_HIGH, i2cw_pkg::PH_START_LOW,
                                         i2cw_pkg::PH_BIT_HIGH, i2cw_pkg::PH_ACK_HIGH,
                                         i2cw_pkg::PH_STOP_HIGH, i2cw_pkg::PH_STOP_REL});
    assign w_adv      = w_unit_end
                        && (w_unit_inc >= (w_long ? {1'b0, i_cfg.hold_units} : 9'd1));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_send) begin
            n_phase = i2cw_pkg::PH_START_HIGH;
        end else if (w_adv) begin
            case (r_phase)
                i2cw_pkg::PH_START_HIGH: n_phase = i2cw_pkg::PH_START_LOW;
                i2cw_pkg::PH_START_LOW:  n_phase = i2cw_pkg::PH_BIT_LOW;
                i2cw_pkg::PH_BIT_LOW:    n_phase = i2cw_pkg::PH_BIT_SET;
                i2cw_pkg::PH_BIT_SET:    n_phase = i2cw_pkg::PH_BIT_HIGH;
                i2cw_pkg::PH_BIT_HIGH: begin
                    n_phase = (r_bit == i2cw_pkg::LAST_BIT) ? i2cw_pkg::PH_ACK_REL
                                                            : i2cw_pkg::PH_BIT_LOW;
                end
                i2cw_pkg::PH_ACK_REL:    n_phase = i2cw_pkg::PH_ACK_HIGH;
                i2cw_pkg::PH_ACK_HIGH:   n_phase = i2cw_pkg::PH_ACK_LOW;
                i2cw_pkg::PH_ACK_LOW:    n_phase = i2cw_pkg::PH_STOP_HIGH;
                i2cw_pkg::PH_STOP_HIGH:  n_phase = i2cw_pkg::PH_STOP_REL;
                default:                 n_phase = i2cw_pkg::PH_IDLE;
            endcase
        end
    end

    // bus levels, counters and shift data
    always_comb begin
        n_bit   = r_bit;
        n_shift = r_shift;
        n_tick  = r_tick;
        n_unit  = r_unit;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        w_done  = 1'b0;
        if (w_send) begin
            n_shift = i_cmd.data_byte;
            n_bit   = '0;
            n_tick  = '0;
            n_unit  = '0;
            n_scl   = 1'b1;
            n_sda   = 1'b1;
        end else if (w_tick) begin
            if (!w_unit_end) begin
                n_tick = w_tick_inc[15:0];
            end else begin
                n_tick = '0;
                n_unit = w_adv ? 8'd0 : w_unit_inc[7:0];
            end
            if (w_adv) begin
                case (r_phase)
                    i2cw_pkg::PH_START_HIGH: n_sda = 1'b0;
                    i2cw_pkg::PH_START_LOW:  n_scl = 1'b0;
                    i2cw_pkg::PH_BIT_LOW:    n_sda = r_shift[i2cw_pkg::LAST_BIT - r_bit];
                    i2cw_pkg::PH_BIT_SET:    n_scl = 1'b1;
                    i2cw_pkg::PH_BIT_HIGH: begin
                        n_scl = 1'b0;
                        if (r_bit == i2cw_pkg::LAST_BIT) begin
                            n_bit = '0;
                            n_sda = 1'b1;
                        end else begin
                            n_bit = r_bit + 3'd1;
                        end
                    end
                    i2cw_pkg::PH_ACK_REL:    n_scl = 1'b1;
                    i2cw_pkg::PH_ACK_HIGH: begin
                        n_ack = i_cmd.sda_in;
                        n_scl = 1'b0;
                    end
                    i2cw_pkg::PH_ACK_LOW: begin
                        n_sda = 1'b0;
                        n_scl = 1'b1;
                    end
                    i2cw_pkg::PH_STOP_HIGH:  n_sda = 1'b1;
                    i2cw_pkg::PH_STOP_REL: begin
                        n_scl  = 1'b0;
                        w_done = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result item for this command
    always_comb begin
        w_res.scl_out  = n_scl;
        w_res.sda_out  = n_sda;
        w_res.busy_res = (n_phase != i2cw_pkg::PH_IDLE);
        w_res.done_res = w_done;
        w_res.nack     = w_done & n_ack;
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cw_pkg::PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_tick  <= '0;
            r_unit  <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_tick  <= n_tick;
            r_unit  <= n_unit;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_mem[r_wr_ptr] <= w_res;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_step) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_step && !w_deq) begin
                r_count <= r_count + 1'b1;
            end else if (w_deq && !w_step) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // a completed transaction leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_done |=> r_phase == i2cw_pkg::PH_IDLE)
        else $error("done reported while sequencer stays busy");

    // nack is only flagged together with done
    a_nack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_res.nack |-> w_res.done_res)
        else $error("nack without done");

    // the result queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    // the sequencer holds still when no command is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_phase) && $stable(r_tick) && $stable(r_unit))
        else $error("sequencer moved without a command");
`endif

endmodule

`default_nettype wire
